### rtl/core/bkl_pkg.sv
// shared types and constants of the bounded keyed list
`default_nettype none

package bkl_pkg;

   // fixed field widths of the request and response beats
   localparam int KEY_W            = 32;
   localparam int PAYLOAD_W        = 64;
   localparam int FUNC_W           = 3;
   localparam int COUNT_W          = 5;
   localparam int CAPACITY_DEFAULT = 16;

   // operation codes carried in the func field
   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND    = 3'd0,
      FUNC_INS_FRONT = 3'd1,
      FUNC_INS_ORD   = 3'd2,
      FUNC_REM_FRONT = 3'd3,
      FUNC_REM_BACK  = 3'd4,
      FUNC_REM_KEY   = 3'd5,
      FUNC_LOOKUP    = 3'd6
   } func_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHUP_RD,
      ST_SHUP_WR,
      ST_SHDN_RD,
      ST_SHDN_WR,
      ST_PLACE,
      ST_DONE
   } state_type;

   // one stored record
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
   } record_type;

   // strobes from the sequencer to the record store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

### rtl/core/bkl_req_if.sv
// request channel of the bounded keyed list
`default_nettype none

interface bkl_req_if import bkl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic signed [KEY_W-1:0] key;
   logic [PAYLOAD_W-1:0]    payload;

   modport source (output valid, output func, output key, output payload, input ready);
   modport sink   (input valid, input func, input key, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/bkl_rsp_if.sv
// response channel of the bounded keyed list
`default_nettype none

interface bkl_rsp_if import bkl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic [COUNT_W-1:0]      count;
   logic                    is_empty;
   logic                    is_full;
   logic signed [KEY_W-1:0] found_key;
   logic [PAYLOAD_W-1:0]    found_payload;

   modport source (output valid, output ok, output count, output is_empty, output is_full,
                   output found_key, output found_payload, input ready);
   modport sink   (input valid, input ok, input count, input is_empty, input is_full,
                   input found_key, input found_payload, output ready);
endinterface

`default_nettype wire

### rtl/core/bkl_store.sv
// record store: one write port, one read port with registered read data
`default_nettype none

module bkl_store import bkl_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire store_ctl_type ctl,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire record_type    wr_data,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      record_type    rd_data
);

   record_type mem [DEPTH];
   record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/bounded_keyed_list.sv
// bounded keyed list: fixed-capacity contiguous list of keyed records
//
// The block takes one request beat (func, key, payload) on req_chan and
// returns exactly one response beat on rsp_chan (ok, count, empty and full
// marks, and the record found by a lookup; zero otherwise).
// Records sit in one store with a write port and a registered read port,
// from position 0 upward. A small sequencer walks the store one entry at a
// time through one key compare unit and small cursor counters: each entry
// scanned or moved passes through a read state and a compare or write state.
// Append writes the new record directly, remove back and refused inserts
// touch no entry, and insert front, ordered insert, remove front, remove by
// key and lookup scan or shift entries first.
// req_chan.ready is high only while the sequencer is idle, so one request is
// in work at a time. The response sits in an output register: a new request
// is taken while the previous response waits, and a finished result holds in
// the sequencer until the output register frees up when the receiver stalls.
// Reset empties the list and drops any pending response. Store contents are
// not cleared; only positions below the count are ever read.
`default_nettype none

module bounded_keyed_list import bkl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   bkl_req_if.sink   req_chan,
   bkl_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   func_type                func_ff, func_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_W-1:0]    payload_ff, payload_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    ok_ff, ok_in;
   logic signed [KEY_W-1:0] fkey_ff, fkey_in;
   logic [PAYLOAD_W-1:0]    fpay_ff, fpay_in;

   // response registers
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic signed [KEY_W-1:0] rsp_fkey_ff, rsp_fkey_in;
   logic [PAYLOAD_W-1:0]    rsp_fpay_ff, rsp_fpay_in;

   // store port
   store_ctl_type    store_ctl;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   record_type       wr_data;
   record_type       rd_data;

   // shared compare and cursor arithmetic
   logic                     key_le;
   logic                     key_eq;
   logic [CNT_W-1:0]         idx_inc;
   logic [CNT_W-1:0]         idx_dec;
   logic [CNT_W-1:0]         pos_inc;
   logic                     is_full;
   logic                     is_empty;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   func_type                 req_func;

   bkl_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign key_le     = $signed(rd_data.key) <= $signed(key_ff);
   assign key_eq     = rd_data.key == key_ff;
   assign idx_inc    = idx_ff + 1'b1;
   assign idx_dec    = idx_ff - 1'b1;
   assign pos_inc    = pos_ff + 1'b1;
   assign is_full    = count_ff == CAP_CNT;
   assign is_empty   = count_ff == '0;
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};
   assign req_func   = func_type'(req_chan.func);

   // sequencer: next state, store strobes and register updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      payload_in   = payload_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      fkey_in      = fkey_ff;
      fpay_in      = fpay_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_fkey_in  = rsp_fkey_ff;
      rsp_fpay_in  = rsp_fpay_ff;
      store_ctl    = '0;
      wr_addr      = idx_ff[IDX_W-1:0];
      rd_addr      = pos_ff[IDX_W-1:0];
      wr_data      = rd_data;

      // response beat taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in    = req_func;
               key_in     = req_chan.key;
               payload_in = req_chan.payload;
               ok_in      = 1'b0;
               fkey_in    = '0;
               fpay_in    = '0;
               pos_in     = '0;
               idx_in     = count_ff;
               case (req_func)
                  FUNC_APPEND: begin
                     if (is_full) begin
                        state_in = ST_DONE;
                     end else begin
                        pos_in   = count_ff;
                        state_in = ST_PLACE;
                     end
                  end
                  FUNC_INS_FRONT: begin
                     state_in = is_full ? ST_DONE : ST_SHUP_RD;
                  end
                  FUNC_INS_ORD: begin
                     state_in = is_full ? ST_DONE : ST_SCAN_RD;
                  end
                  FUNC_REM_FRONT: begin
                     idx_in   = '0;
                     state_in = is_empty ? ST_DONE : ST_SHDN_RD;
                  end
                  FUNC_REM_BACK: begin
                     if (!is_empty) begin
                        count_in = count_ff - 1'b1;
                        ok_in    = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  FUNC_REM_KEY, FUNC_LOOKUP: begin
                     state_in = ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // scan: read the entry at the cursor or finish at the count
         ST_SCAN_RD: begin
            if (pos_ff == count_ff) begin
               state_in = (func_ff == FUNC_INS_ORD) ? ST_SHUP_RD : ST_DONE;
            end else begin
               store_ctl.rd_en = 1'b1;
               state_in        = ST_SCAN_CHK;
            end
         end

         // scan: compare the entry just read
         ST_SCAN_CHK: begin
            if (func_ff == FUNC_INS_ORD) begin
               if (key_le) begin
                  pos_in   = pos_inc;
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_SHUP_RD;
               end
            end else if (key_eq) begin
               if (func_ff == FUNC_LOOKUP) begin
                  ok_in    = 1'b1;
                  fkey_in  = rd_data.key;
                  fpay_in  = rd_data.payload;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = pos_ff;
                  state_in = ST_SHDN_RD;
               end
            end else begin
               pos_in   = pos_inc;
               state_in = ST_SCAN_RD;
            end
         end

         // shift up: move entry idx-1 to idx, down to the insert position
         ST_SHUP_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               store_ctl.rd_en = 1'b1;
               rd_addr         = idx_dec[IDX_W-1:0];
               state_in        = ST_SHUP_WR;
            end
         end

         ST_SHUP_WR: begin
            store_ctl.wr_en = 1'b1;
            idx_in          = idx_dec;
            state_in        = ST_SHUP_RD;
         end

         // shift down: move entry idx+1 to idx up to the last record
         ST_SHDN_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               store_ctl.rd_en = 1'b1;
               rd_addr         = idx_inc[IDX_W-1:0];
               state_in        = ST_SHDN_WR;
            end
         end

         ST_SHDN_WR: begin
            store_ctl.wr_en = 1'b1;
            idx_in          = idx_inc;
            state_in        = ST_SHDN_RD;
         end

         // write the new record at its position
         ST_PLACE: begin
            store_ctl.wr_en = 1'b1;
            wr_addr         = pos_ff[IDX_W-1:0];
            wr_data         = '{key: key_ff, payload: payload_ff};
            count_in        = count_ff + 1'b1;
            ok_in           = 1'b1;
            state_in        = ST_DONE;
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_count_in = count_wide[COUNT_W-1:0];
               rsp_empty_in = is_empty;
               rsp_full_in  = is_full;
               rsp_fkey_in  = fkey_ff;
               rsp_fpay_in  = fpay_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      payload_ff   <= payload_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      ok_ff        <= ok_in;
      fkey_ff      <= fkey_in;
      fpay_ff      <= fpay_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_fkey_ff  <= rsp_fkey_in;
      rsp_fpay_ff  <= rsp_fpay_in;
   end

   // channel outputs
   assign req_chan.ready         = state_ff == ST_IDLE;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ok            = rsp_ok_ff;
   assign rsp_chan.count         = rsp_count_ff;
   assign rsp_chan.is_empty      = rsp_empty_ff;
   assign rsp_chan.is_full       = rsp_full_ff;
   assign rsp_chan.found_key     = rsp_fkey_ff;
   assign rsp_chan.found_payload = rsp_fpay_ff;

endmodule

`default_nettype wire

### sim/tb_bounded_keyed_list.sv
// self-checking testbench of the bounded keyed list: shadow list, random op mix, handshake stalls
`default_nettype none

module tb_bounded_keyed_list import bkl_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 10;
   localparam int LIST_CAP    = CAPACITY_DEFAULT;
   localparam int PHASE_ITEMS = 430;

   // func code that maps to no operation
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;

   typedef struct {
      logic                    ok;
      logic [COUNT_W-1:0]      count;
      logic                    is_empty;
      logic                    is_full;
      logic signed [KEY_W-1:0] found_key;
      logic [PAYLOAD_W-1:0]    found_payload;
   } list_reply_t;

   // shadow copy of the list plus the replies still owed by the block
   class keyed_list_tracker;
      logic signed [KEY_W-1:0] keys [LIST_CAP];
      logic [PAYLOAD_W-1:0]    payloads [LIST_CAP];
      int                      fill;
      list_reply_t             awaited [$];
      int                      faults;

      function new();
         fill   = 0;
         faults = 0;
      endfunction

      function void note_failure(string msg);
         faults++;
         if (faults <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // some key currently held, so removals and lookups hit often
      function logic signed [KEY_W-1:0] held_key();
         if (fill == 0) return $urandom;
         return keys[$urandom_range(fill - 1)];
      endfunction

      // lowest position holding key, fill when missing
      function int locate(logic signed [KEY_W-1:0] key);
         int pos;
         pos = 0;
         while (pos < fill && keys[pos] != key) pos++;
         return pos;
      endfunction

      // apply one accepted request beat and queue the reply it must produce
      function void note_request(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
         list_reply_t r;
         int          pos;
         int          i;
         r = '{default: 0};
         case (func)
            FUNC_APPEND, FUNC_INS_FRONT, FUNC_INS_ORD: begin
               if (fill < LIST_CAP) begin
                  if (func == FUNC_APPEND) begin
                     pos = fill;
                  end else if (func == FUNC_INS_FRONT) begin
                     pos = 0;
                  end else begin
                     // equal keys: new record lands after them
                     pos = 0;
                     while (pos < fill && keys[pos] <= key) pos++;
                  end
                  for (i = fill; i > pos; i--) begin
                     keys[i]     = keys[i - 1];
                     payloads[i] = payloads[i - 1];
                  end
                  keys[pos]     = key;
                  payloads[pos] = payload;
                  fill++;
                  r.ok = 1'b1;
               end
            end
            FUNC_REM_FRONT, FUNC_REM_BACK, FUNC_REM_KEY: begin
               if (func == FUNC_REM_FRONT) pos = 0;
               else if (func == FUNC_REM_BACK) pos = fill - 1;
               else pos = locate(key);
               if (fill > 0 && pos < fill) begin
                  for (i = pos; i + 1 < fill; i++) begin
                     keys[i]     = keys[i + 1];
                     payloads[i] = payloads[i + 1];
                  end
                  fill--;
                  r.ok = 1'b1;
               end
            end
            FUNC_LOOKUP: begin
               pos = locate(key);
               if (pos < fill) begin
                  r.ok            = 1'b1;
                  r.found_key     = keys[pos];
                  r.found_payload = payloads[pos];
               end
            end
            default: ;
         endcase
         r.count    = COUNT_W'(fill);
         r.is_empty = (fill == 0);
         r.is_full  = (fill >= LIST_CAP);
         awaited.push_back(r);
      endfunction

      // compare one response beat with the oldest owed reply
      function void check_reply(list_reply_t got);
         list_reply_t want;
         if (awaited.size() == 0) begin
            note_failure($sformatf("unexpected response beat ok=%0b count=%0d",
                                   got.ok, got.count));
            return;
         end
         want = awaited.pop_front();
         if (got.ok !== want.ok || got.count !== want.count ||
             got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
             got.found_key !== want.found_key || got.found_payload !== want.found_payload)
            note_failure($sformatf(
               "reply mismatch exp ok=%0b cnt=%0d e=%0b f=%0b key=%0d pay=%h got ok=%0b cnt=%0d e=%0b f=%0b key=%0d pay=%h",
               want.ok, want.count, want.is_empty, want.is_full, want.found_key,
               want.found_payload, got.ok, got.count, got.is_empty, got.is_full,
               got.found_key, got.found_payload));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bkl_req_if req_bus ();
   bkl_rsp_if rsp_bus ();

   keyed_list_tracker tracker = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   bounded_keyed_list #(.CAPACITY(LIST_CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // check every response beat
   always @(posedge clock) begin : watch_replies
      list_reply_t seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.ok            = rsp_bus.ok;
         seen.count         = rsp_bus.count;
         seen.is_empty      = rsp_bus.is_empty;
         seen.is_full       = rsp_bus.is_full;
         seen.found_key     = rsp_bus.found_key;
         seen.found_payload = rsp_bus.found_payload;
         tracker.check_reply(seen);
      end
   end

   // offer one request beat, with random idle cycles ahead of it
   task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [KEY_W-1:0] key,
                          input logic [PAYLOAD_W-1:0] payload);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.func    = func;
      req_bus.key     = key;
      req_bus.payload = payload;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(func, key, payload);
   endtask

   // stop offering, then wait for every owed reply
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   // empty list, fill to capacity with mixed inserts, full list, duplicates, missing keys
   task automatic run_directed();
      logic signed [KEY_W-1:0] fill_keys [LIST_CAP] = '{
         32'sh7fffffff, 32'sh80000000, 5, 5, -1, 3, 5, 100,
         -100, 7, 0, 42, -7, 9, 5, 12};
      logic [FUNC_W-1:0]       func;
      logic [PAYLOAD_W-1:0]    payload;
      int                      i;
      send_op(FUNC_REM_FRONT, 0, 0);
      send_op(FUNC_REM_BACK, 0, 0);
      send_op(FUNC_REM_KEY, 5, 0);
      send_op(FUNC_LOOKUP, 5, 0);
      send_op(FUNC_SPARE, 5, '1);
      for (i = 0; i < LIST_CAP; i++) begin
         if (i < 4 || i % 3 == 0) func = FUNC_INS_ORD;
         else if (i % 3 == 1) func = FUNC_APPEND;
         else func = FUNC_INS_FRONT;
         if (i == 0) payload = '1;
         else if (i == 1) payload = '0;
         else payload = {$urandom, $urandom};
         send_op(func, fill_keys[i], payload);
      end
      send_op(FUNC_APPEND, 1, {$urandom, $urandom});
      send_op(FUNC_INS_FRONT, 1, {$urandom, $urandom});
      send_op(FUNC_INS_ORD, 1, {$urandom, $urandom});
      send_op(FUNC_LOOKUP, 5, 0);
      send_op(FUNC_LOOKUP, 1234, 0);
      send_op(FUNC_REM_KEY, 5, 0);
      send_op(FUNC_REM_KEY, 1234, 0);
      send_op(FUNC_REM_FRONT, 0, 0);
      send_op(FUNC_REM_BACK, 0, 0);
   endtask

   // one random op; grow_pct biases toward inserts so full and empty both come up
   task automatic random_op(input int grow_pct, output bit counted);
      int                      r;
      logic [FUNC_W-1:0]       func;
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
      r = $urandom_range(99);
      if (r < 2) begin
         func = FUNC_SPARE;
      end else if (r < 2 + grow_pct) begin
         case ($urandom_range(2))
            0:       func = FUNC_APPEND;
            1:       func = FUNC_INS_FRONT;
            default: func = FUNC_INS_ORD;
         endcase
      end else begin
         case ($urandom_range(3))
            0:       func = FUNC_REM_FRONT;
            1:       func = FUNC_REM_BACK;
            2:       func = FUNC_REM_KEY;
            default: func = FUNC_LOOKUP;
         endcase
      end
      r = $urandom_range(99);
      if (r < 40) begin
         key = tracker.held_key();
      end else if (r < 75) begin
         key = int'($urandom_range(16)) - 8;
      end else if (r < 85) begin
         case ($urandom_range(3))
            0:       key = 32'sh7fffffff;
            1:       key = 32'sh80000000;
            2:       key = -1;
            default: key = 0;
         endcase
      end else begin
         key = $urandom;
      end
      r = $urandom_range(99);
      if (r < 10) payload = '1;
      else if (r < 20) payload = '0;
      else payload = {$urandom, $urandom};
      send_op(func, key, payload);
      counted = (func != FUNC_SPARE);
   endtask

   // main sequence
   initial begin
      int phase;
      int n;
      int guard;
      bit counted;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = '0;
      req_bus.key     = '0;
      req_bus.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         n = 0;
         while (n < PHASE_ITEMS) begin
            // long receiver hold-off while requests keep coming
            if (phase == 0 && n == 150) hold_left = 400;
            // sender pause until every reply is back
            if (n == 300) wait_drained();
            random_op(((n / 40) % 2) ? 25 : 75, counted);
            if (counted) n++;
         end
         wait_drained();
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      guard = 0;
      while (tracker.outstanding() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (2 * LIST_CAP + 8) @(negedge clock);
      if (tracker.outstanding() != 0)
         tracker.note_failure($sformatf("%0d replies never arrived", tracker.outstanding()));
      if (tracker.faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
